[src/pixel_step_toward_limiter_top_macros.svh]
// Assertion macros for the pixel step-toward limiter.
`ifndef PIXEL_STEP_TOWARD_LIMITER_TOP_MACROS_SVH
`define PIXEL_STEP_TOWARD_LIMITER_TOP_MACROS_SVH
`ifndef SYNTH
// Condition must hold in the same cycle as its trigger.
`define PSTL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pstl assertion failed");
// Condition must hold in the cycle after its trigger.
`define PSTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pstl assertion failed");
`else
`define PSTL_ASSERT_NOW(label, clk, rst, ante, cons)
`define PSTL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/pstl_pkg.sv]
// Shared types and constants for the pixel step-toward limiter.
`default_nettype none

package pstl_pkg;

   localparam int unsigned LANES  = 4;
   localparam int unsigned CHAN_W = 8;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [LANES-1:0] pix_type;

   // Load strobe and sideband bit handed from the top level to the merge stage.
   typedef struct packed {
      logic load;
      logic last;
   } load_type;

endpackage

`default_nettype wire

[src/pixel_step_toward_limiter_top.sv]
// Top level of the pixel step-toward limiter: four channel lanes and a merge stage.
// A result beat appears in the output register in the cycle after its request beat is accepted.
// Throughput: one pixel per cycle while the response side does not stall; the single
// output register sets the rate and a new request is taken in any cycle where that register is empty or being drained.
// Reset: synchronous, active high; clears the output valid and sets step_limit to 0.
`default_nettype none
`include "pixel_step_toward_limiter_top_macros.svh"

module pixel_step_toward_limiter_top (
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       csr_wr_en,
   input  var logic [7:0] csr_wr_data,
   input  var logic       req_valid,
   output var logic       req_stall,
   input  var logic [7:0] req_cur_c0,
   input  var logic [7:0] req_cur_c1,
   input  var logic [7:0] req_cur_c2,
   input  var logic [7:0] req_cur_c3,
   input  var logic [7:0] req_tgt_c0,
   input  var logic [7:0] req_tgt_c1,
   input  var logic [7:0] req_tgt_c2,
   input  var logic [7:0] req_tgt_c3,
   input  var logic       req_last_in,
   output var logic       rsp_valid,
   input  var logic       rsp_stall,
   output var logic [7:0] rsp_out_c0,
   output var logic [7:0] rsp_out_c1,
   output var logic [7:0] rsp_out_c2,
   output var logic [7:0] rsp_out_c3,
   output var logic       rsp_last_out
);

   // The step limit register. The user must write it only while the block is idle, so
   // a beat in flight never sees it change; the block itself does not enforce this.
   pstl_pkg::chan_type step_limit_ff, step_limit_in;

   always_comb begin
      step_limit_in = csr_wr_en ? csr_wr_data : step_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= '0;
      end else begin
         step_limit_ff <= step_limit_in;
      end
   end

   // Gather the channels of each side into one vector per pixel so that the
   // lanes can be generated.
   pstl_pkg::pix_type cur_pix;
   pstl_pkg::pix_type tgt_pix;
   pstl_pkg::pix_type lane_res;
   pstl_pkg::pix_type out_pix;

   assign cur_pix[0] = req_cur_c0;
   assign cur_pix[1] = req_cur_c1;
   assign cur_pix[2] = req_cur_c2;
   assign cur_pix[3] = req_cur_c3;
   assign tgt_pix[0] = req_tgt_c0;
   assign tgt_pix[1] = req_tgt_c1;
   assign tgt_pix[2] = req_tgt_c2;
   assign tgt_pix[3] = req_tgt_c3;

   // Each lane handles one channel independently; all share the limit.
   for (genvar g = 0; g < pstl_pkg::LANES; g++) begin : g_lane
      pstl_lane u_lane (
         .cur    (cur_pix[g]),
         .tgt    (tgt_pix[g]),
         .limit  (step_limit_ff),
         .result (lane_res[g])
      );
   end

   // A request beat is taken whenever the output register is empty or its
   // beat leaves in the same cycle.
   logic               out_valid;
   logic               accept;
   pstl_pkg::load_type ctl;

   assign req_stall = out_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign ctl.load  = accept;
   assign ctl.last  = req_last_in;

   pstl_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .lanes (lane_res),
      .pix   (out_pix),
      .last  (rsp_last_out),
      .valid (out_valid),
      .stall (rsp_stall)
   );

   assign rsp_valid  = out_valid;
   assign rsp_out_c0 = out_pix[0];
   assign rsp_out_c1 = out_pix[1];
   assign rsp_out_c2 = out_pix[2];
   assign rsp_out_c3 = out_pix[3];

   // High while the limit disables every move.
   logic limit_off;

   assign limit_off = (step_limit_ff == '0);

   // An accepted beat always lands in the output register.
   `PSTL_ASSERT_NEXT(a_accept_fills, clock, reset, accept, rsp_valid)
   // Back-pressure on the request side only comes from a held result.
   `PSTL_ASSERT_NOW(a_stall_has_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // The last-pixel mark follows its own beat.
   `PSTL_ASSERT_NEXT(a_last_follows, clock, reset, accept, rsp_last_out == $past(req_last_in))
   // With a zero limit the pixel passes unchanged.
   `PSTL_ASSERT_NEXT(a_zero_limit, clock, reset, accept && limit_off, out_pix == $past(cur_pix))

endmodule

`default_nettype wire

[src/pstl_lane.sv]
// One channel lane: moves a current value toward a target under the step limit.
`default_nettype none

module pstl_lane (
   input  var pstl_pkg::chan_type cur,
   input  var pstl_pkg::chan_type tgt,
   input  var pstl_pkg::chan_type limit,
   output var pstl_pkg::chan_type result
);

   logic                         up;
   pstl_pkg::chan_type           mag;
   logic [pstl_pkg::CHAN_W:0]    limit_p1;
   pstl_pkg::chan_type           half;
   logic [pstl_pkg::CHAN_W:0]    back_off;
   pstl_pkg::chan_type           step;

   always_comb begin
      up       = (tgt >= cur);
      mag      = up ? (tgt - cur) : (cur - tgt);
      limit_p1 = {1'b0, limit} + {{pstl_pkg::CHAN_W{1'b0}}, 1'b1};
      half     = limit_p1[pstl_pkg::CHAN_W:1];
      back_off = limit_p1 - {1'b0, mag};

      // Beyond the limit nothing moves; within half of it the full distance
      // is taken; in between the step shrinks as the distance grows.
      if ((mag == '0) || (mag > limit)) begin
         step = '0;
      end else if (mag <= half) begin
         step = mag;
      end else begin
         step = back_off[pstl_pkg::CHAN_W-1:0];
      end

      result = up ? (cur + step) : (cur - step);
   end

endmodule

`default_nettype wire

[src/pstl_merge.sv]
// Merge stage: gathers the lane results into the registered output beat.
`default_nettype none

module pstl_merge (
   input  var logic               clock,
   input  var logic               reset,
   input  var pstl_pkg::load_type ctl,
   input  var pstl_pkg::pix_type  lanes,
   output var pstl_pkg::pix_type  pix,
   output var logic               last,
   output var logic               valid,
   input  var logic               stall
);

   logic              valid_ff, valid_in;
   pstl_pkg::pix_type pix_ff, pix_in;
   logic              last_ff, last_in;

   always_comb begin
      valid_in = valid_ff;
      pix_in   = pix_ff;
      last_in  = last_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         pix_in   = lanes;
         last_in  = ctl.last;
      end else if (!stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      last_ff <= last_in;
   end

   assign pix   = pix_ff;
   assign last  = last_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire
